// ===== rtl/cartridge_bank_mapper_irq_core_assert.svh =====
// Assertion macros used by the checker file of the bank mapper.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_CORE_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define CBM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CBM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/cbm_pkg.sv =====
// Shared types and constants of the cartridge bank mapper.
package cbm_pkg;

    // Result kinds carried on m_tuser
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_PRG    = 2'd1;
    localparam logic [1:0] KIND_CHR    = 2'd2;
    localparam logic [1:0] KIND_MIRROR = 2'd3;

    // Input beat kinds carried on s_tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Decoded addresses
    localparam logic [3:0]  PRG0_NIBBLE = 4'h8;
    localparam logic [3:0]  PRG1_NIBBLE = 4'hA;
    localparam logic [15:0] CHR_LOW     = 16'hB000;
    localparam logic [15:0] CHR_HIGH    = 16'hE00C;
    localparam logic [15:0] MIRROR_ADDR = 16'h9000;
    localparam logic [15:0] LATCH_LO    = 16'hF000;
    localparam logic [15:0] LATCH_HI    = 16'hF004;
    localparam logic [15:0] IRQ_CTRL    = 16'hF008;
    localparam logic [15:0] IRQ_ACK     = 16'hF00C;

    // Character bank values that select on-board RAM
    localparam logic [7:0] CHR_RAM_A = 8'd6;
    localparam logic [7:0] CHR_RAM_B = 8'd7;

    localparam int unsigned S_DATA_W = 24;
    localparam int unsigned M_DATA_W = 16;

    // Bit positions of the result fields within m_tdata
    localparam int unsigned M_SLOT_LSB   = 0;
    localparam int unsigned M_BANK_LSB   = 3;
    localparam int unsigned M_RAM_BIT    = 11;
    localparam int unsigned M_MIRROR_LSB = 12;
    localparam int unsigned M_PULSE_BIT  = 14;

    // Result data, packed MSB first to match m_tdata
    typedef struct packed {
        logic       pad;
        logic       irq_pulse;
        logic [1:0] mirroring;
        logic       chr_is_ram;
        logic [7:0] bank;
        logic [2:0] slot;
    } cbm_result_t;

    // Interrupt unit commands, already qualified by the input handshake
    typedef struct packed {
        logic       tick;
        logic       latch_lo;
        logic       latch_hi;
        logic       ctrl;
        logic       ack;
        logic [7:0] value;
    } cbm_irq_cmd_t;

endpackage

// ===== rtl/cbm_irq.sv =====
// Scanline interrupt counter with latch, enable and rearm control.
module cbm_irq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cbm_pkg::cbm_irq_cmd_t cmd,
    output logic                  irq_pulse
);
    import cbm_pkg::*;

    logic [7:0] latch_reg;
    logic [7:0] count_reg;
    logic       on_reg;
    logic       rearm_reg;

    // Flag the tick that wraps the counter
    assign irq_pulse = cmd.tick && on_reg && (count_reg == 8'hFF);

    // Update latch, counter and enables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg <= '0;
            count_reg <= '0;
            on_reg    <= 1'b0;
            rearm_reg <= 1'b0;
        end else begin
            if (cmd.latch_lo) begin
                latch_reg[3:0] <= cmd.value[3:0];
            end
            if (cmd.latch_hi) begin
                latch_reg[7:4] <= cmd.value[3:0];
            end
            if (cmd.ctrl) begin
                on_reg    <= cmd.value[1];
                rearm_reg <= cmd.value[0];
                count_reg <= latch_reg;
            end
            if (cmd.ack) begin
                on_reg <= rearm_reg;
            end
            if (cmd.tick && on_reg) begin
                if (count_reg == 8'hFF) begin
                    count_reg <= latch_reg;
                    on_reg    <= rearm_reg;
                end else begin
                    count_reg <= count_reg + 8'd1;
                end
            end
        end
    end

endmodule

// ===== rtl/cartridge_bank_mapper_irq_core.sv =====
// Top level of the cartridge bank mapper: write decode, character banks and result register.
//
// Each input beat is either a CPU bus write (s_tuser low) or a scanline tick (s_tuser high)
// and gives exactly one result beat, in the cycle after it is accepted. A new beat is taken in
// every cycle while the result register is empty or being drained, so the sustained rate is
// one item per cycle; the decode, the character nibble merge and the counter increment all
// sit in the single stage in front of the result register. Stalling m_tready holds the
// current result and drops s_tready until it is taken. Reset clears the character banks,
// the interrupt latch, counter and enables.
module cartridge_bank_mapper_irq_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // address [15:0], value [23:16]
    input  logic [cbm_pkg::S_DATA_W-1:0]   s_tdata,
    // mode [0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot [2:0], bank [10:3], chr_is_ram [11], mirroring [13:12], irq_pulse [14], zero [15]
    output logic [cbm_pkg::M_DATA_W-1:0]   m_tdata,
    // update_kind [1:0]
    output logic [1:0]                     m_tuser
);
    import cbm_pkg::*;

    logic [15:0]  addr;
    logic [7:0]   val;
    logic         accept;
    logic         is_write;
    logic [2:0]   chr_slot;
    logic [7:0]   chr_old;
    logic [7:0]   chr_new;
    logic         chr_hit;
    logic         irq_pulse;
    cbm_irq_cmd_t irq_cmd;
    cbm_result_t  res;
    logic [1:0]   kind;

    logic [7:0]        chr_reg [8];
    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    assign addr     = s_tdata[15:0];
    assign val      = s_tdata[23:16];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_write = (s_tuser == MODE_WRITE);

    // Character slot and nibble merge
    assign chr_hit  = (addr >= CHR_LOW) && (addr <= CHR_HIGH);
    assign chr_slot = {addr[13:12], addr[11] | addr[3]} + 3'd2;
    assign chr_old  = chr_reg[chr_slot];
    assign chr_new  = addr[2] ? {val[3:0], chr_old[3:0]} : {chr_old[7:4], val[3:0]};

    // Interrupt commands, gated by the handshake
    always_comb begin
        irq_cmd          = '0;
        irq_cmd.value    = val;
        irq_cmd.tick     = accept && !is_write;
        irq_cmd.latch_lo = accept && is_write && (addr == LATCH_LO);
        irq_cmd.latch_hi = accept && is_write && (addr == LATCH_HI);
        irq_cmd.ctrl     = accept && is_write && (addr == IRQ_CTRL);
        irq_cmd.ack      = accept && is_write && (addr == IRQ_ACK);
    end

    cbm_irq u_irq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (irq_cmd),
        .irq_pulse (irq_pulse)
    );

    // Decode the beat into one result
    always_comb begin
        res  = '0;
        kind = KIND_NONE;
        if (!is_write) begin
            res.irq_pulse = irq_pulse;
        end else if (addr[15:12] == PRG0_NIBBLE) begin
            kind     = KIND_PRG;
            res.bank = val;
        end else if (addr[15:12] == PRG1_NIBBLE) begin
            kind     = KIND_PRG;
            res.slot = 3'd1;
            res.bank = val;
        end else if (chr_hit) begin
            kind           = KIND_CHR;
            res.slot       = chr_slot;
            res.bank       = chr_new;
            res.chr_is_ram = (chr_new == CHR_RAM_A) || (chr_new == CHR_RAM_B);
        end else if (addr == MIRROR_ADDR) begin
            kind          = KIND_MIRROR;
            res.mirroring = val[1:0];
        end
    end

    // Write the addressed character bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                chr_reg[i] <= '0;
            end
        end else if (accept && is_write && chr_hit &&
                     (addr[15:12] != PRG0_NIBBLE) && (addr[15:12] != PRG1_NIBBLE)) begin
            chr_reg[chr_slot] <= chr_new;
        end
    end

    // Result register: load on accept, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= res;
            m_tuser_reg <= kind;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/cbm_checker.sv =====
// Port-level checks of the bank mapper and their binding to the top level.
`include "cartridge_bank_mapper_irq_core_assert.svh"

module cbm_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [cbm_pkg::S_DATA_W-1:0] s_tdata,
    input logic                         s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [cbm_pkg::M_DATA_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser
);
    import cbm_pkg::*;

    // Hold a stalled result beat
    `CBM_ASSERT(a_m_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")

    // Leave reset with an empty result register
    `CBM_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid right after reset")

    // Accept input whenever the result register is empty
    `CBM_ASSERT(a_ready_empty, !m_tvalid |-> s_tready, "input stalled with empty result register")

    // Pulse only on beats that report no bank update
    `CBM_ASSERT(a_pulse_kind, m_tvalid && m_tdata[M_PULSE_BIT] |-> m_tuser == KIND_NONE, "interrupt pulse on an update beat")

    // Flag character RAM only for bank six or seven of a character update
    `CBM_ASSERT(a_ram_bank, m_tvalid && m_tdata[M_RAM_BIT] |-> m_tuser == KIND_CHR && (m_tdata[10:3] == CHR_RAM_A || m_tdata[10:3] == CHR_RAM_B), "character RAM flag on a wrong bank")

    logic unused_inputs;
    assign unused_inputs = s_tvalid ^ (^s_tdata) ^ s_tuser;

endmodule

bind cartridge_bank_mapper_irq_core cbm_checker u_cbm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
